>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When pre holds at an edge, post must hold at the same edge.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

>>> hdl/gdnc_pkg.sv
package gdnc_pkg;

  // Item kinds carried on tuser
  localparam logic KIND_DATE   = 1'b0;
  localparam logic KIND_NUMBER = 1'b1;

  // Easter month codes
  localparam logic [2:0] EASTER_MARCH = 3'd3;
  localparam logic [2:0] EASTER_APRIL = 3'd4;

  // Pipeline depth of the two sub-blocks
  localparam int J2D_LAT = 5;
  localparam int CAL_LAT = 3;

  localparam int MONTHS_PER_YEAR = 12;

  // Day number range covering years 1 to 9999
  localparam logic [22:0] JDN_MIN = 23'd1721426;
  localparam logic [22:0] JDN_MAX = 23'd5373484;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // Day number split: divide by 146097 and by 1461 through reciprocals
  localparam logic [23:0] JDN_BIAS   = 24'd32044;
  localparam logic [17:0] DAYS_400Y  = 18'd146097;
  localparam logic [7:0]  RECIP_400Y = 8'd229;   // floor(2^25 / 146097)
  localparam logic [10:0] DAYS_4Y    = 11'd1461;
  localparam logic [7:0]  RECIP_4Y   = 8'd179;   // floor(2^18 / 1461)
  localparam logic [14:0] YEAR_BIAS  = 15'd4800;

  // Year splits: exact for every year up to 9999 (by 19 below 14563)
  localparam logic [13:0] RECIP_19  = 14'd13798; // ceil(2^18 / 19)
  localparam logic [12:0] RECIP_100 = 13'd5243;  // ceil(2^19 / 100)

  // 1200 - 48 + 12 - 32045, folded into one subtraction
  localparam logic [22:0] JDN_DATE_BIAS = 23'd30881;

  typedef logic [15:0][8:0]   day_tab_t;
  typedef logic [31:0][4:0]   h19_tab_t;
  typedef logic [127:0][6:0]  seven_tab_t;
  typedef logic [127:0][2:0]  mod7_tab_t;

  // Word as it travels down the pipeline
  typedef struct packed {
    logic        kind;
    logic        ok;
    logic        feb29;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [22:0] jdn;
  } gdnc_item_t;

  // Finished result ahead of the output register
  typedef struct packed {
    logic        ok;
    logic [22:0] jdn;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        leap;
    logic [2:0]  easter_month;
    logic [4:0]  easter_day;
  } gdnc_result_t;

  // Days from March 1 to the start of month index k (March = 0)
  function automatic day_tab_t build_days_before();
    day_tab_t tab;
    tab = '0;
    for (int k = 0; k < MONTHS_PER_YEAR; k++) begin
      tab[k] = 9'((153 * k + 2) / 5);
    end
    return tab;
  endfunction

  // (19 * a) mod 30, golden number term of the epact
  function automatic h19_tab_t build_h19();
    h19_tab_t tab;
    for (int a = 0; a < 32; a++) begin
      tab[a] = 5'((19 * a) % 30);
    end
    return tab;
  endfunction

  // Century part of the epact: b - b/4 - (b - (b+8)/25 + 1)/3 + 15
  function automatic seven_tab_t build_century();
    seven_tab_t tab;
    int f;
    int g;
    for (int b = 0; b < 128; b++) begin
      f = (b + 8) / 25;
      g = (b - f + 1) / 3;
      tab[b] = 7'(b - b / 4 - g + 15);
    end
    return tab;
  endfunction

  // Year-in-century part of the weekday term: 2*(c/4) - c%4, offset by 3
  function automatic seven_tab_t build_yic();
    seven_tab_t tab;
    for (int c = 0; c < 128; c++) begin
      tab[c] = 7'(2 * (c / 4) - c % 4 + 3);
    end
    return tab;
  endfunction

  function automatic mod7_tab_t build_mod7();
    mod7_tab_t tab;
    for (int i = 0; i < 128; i++) begin
      tab[i] = 3'(i % 7);
    end
    return tab;
  endfunction

  localparam day_tab_t   DAYS_BEFORE = build_days_before();
  localparam h19_tab_t   H19_TAB     = build_h19();
  localparam seven_tab_t CENT_TAB    = build_century();
  localparam seven_tab_t YIC_TAB     = build_yic();
  localparam mod7_tab_t  MOD7_TAB    = build_mod7();

  // Longest day allowed per month code, February taken as 29
  function automatic logic [4:0] max_days(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd29;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/gdnc_jdn_split.sv
// Day number to calendar date, five stages.
// Date words pass through untouched.
module gdnc_jdn_split import gdnc_pkg::*; (
  input  logic       clk,
  input  logic       advance,
  input  gdnc_item_t item_in,
  output gdnc_item_t item_out
);

  gdnc_item_t  s1_item, s2_item, s3_item, s4_item;
  logic [25:0] s1_x0;
  logic [7:0]  s1_q0;
  logic [7:0]  s2_b, s3_b, s4_b;
  logic [17:0] s2_r1, s3_x1;
  logic [6:0]  s3_q1, s4_dd;
  logic [10:0] s4_r2;

  logic [23:0] a_sum;
  logic [25:0] x0;
  logic [33:0] prod0;
  logic [25:0] back0, rem0;
  logic        ge0;
  logic [17:0] x1;
  logic [25:0] prod1;
  logic [17:0] back1, rem1;
  logic        ge1;
  logic [11:0] rem1_fix;
  logic [11:0] e_sum, e_off;
  logic [8:0]  doy;
  logic [3:0]  mm;
  logic [8:0]  dom;
  logic [14:0] yr;
  logic        next_year;
  gdnc_item_t  date_item;

  // Stage 1: 4*(j + 32044) + 3, estimate of the 400-year cycle count
  always_comb begin
    a_sum = {1'b0, item_in.jdn} + JDN_BIAS;
    x0    = {a_sum, 2'b11};
    prod0 = {8'd0, x0} * {26'd0, RECIP_400Y};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= item_in;
      s1_x0   <= x0;
      s1_q0   <= prod0[32:25];
    end
  end

  // Stage 2: the estimate is low by at most one, correct it
  always_comb begin
    back0 = {18'd0, s1_q0} * {8'd0, DAYS_400Y};
    rem0  = s1_x0 - back0;
    ge0   = rem0 >= {8'd0, DAYS_400Y};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_item <= s1_item;
      s2_b    <= ge0 ? s1_q0 + 8'd1 : s1_q0;
      s2_r1   <= ge0 ? rem0[17:0] - DAYS_400Y : rem0[17:0];
    end
  end

  // Stage 3: 4*c + 3 falls out of the remainder; estimate the 4-year count
  always_comb begin
    x1    = s2_r1 + {16'd0, s2_b[1:0]};
    prod1 = {8'd0, x1} * {18'd0, RECIP_4Y};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_item <= s2_item;
      s3_b    <= s2_b;
      s3_x1   <= x1;
      s3_q1   <= prod1[24:18];
    end
  end

  // Stage 4: correct the 4-year count
  always_comb begin
    back1    = {11'd0, s3_q1} * {7'd0, DAYS_4Y};
    rem1     = s3_x1 - back1;
    ge1      = rem1 >= {7'd0, DAYS_4Y};
    rem1_fix = ge1 ? rem1[11:0] - {1'b0, DAYS_4Y} : rem1[11:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_item <= s3_item;
      s4_b    <= s3_b;
      s4_dd   <= ge1 ? s3_q1 + 7'd1 : s3_q1;
      s4_r2   <= rem1_fix[10:0];
    end
  end

  // Stage 5: day of the March-based year, then month, day and year
  always_comb begin
    e_sum = {1'b0, s4_r2} + {10'd0, s4_dd[1:0]};
    e_off = e_sum - 12'd3;
    doy   = e_off[10:2];
    mm    = '0;
    for (int k = 1; k < MONTHS_PER_YEAR; k++) begin
      if (DAYS_BEFORE[k] <= doy) mm = 4'(k);
    end
    dom       = doy - DAYS_BEFORE[mm] + 9'd1;
    next_year = mm >= 4'd10;
    yr        = {7'd0, s4_b} * 15'd100 + {8'd0, s4_dd} + {14'd0, next_year} - YEAR_BIAS;

    date_item = s4_item;
    if (s4_item.kind == KIND_NUMBER) begin
      date_item.day   = dom[4:0];
      date_item.month = next_year ? mm - 4'd9 : mm + 4'd3;
      date_item.year  = yr[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_out <= date_item;
    end
  end

endmodule

>>> hdl/gdnc_calendar.sv
// Year properties, day number of a date, and Gregorian Easter, three stages.
module gdnc_calendar import gdnc_pkg::*; (
  input  logic         clk,
  input  logic         advance,
  input  gdnc_item_t   item_in,
  output gdnc_result_t res_out
);

  gdnc_item_t  e1_item, e2_item;
  logic [9:0]  e1_q19;
  logic [7:0]  e1_q100;
  logic        e1_a0;
  logic [22:0] e1_p;
  logic [4:0]  e2_a19, e2_h;
  logic [6:0]  e2_t;
  logic        e2_leap;

  logic [27:0] prod19;
  logic [26:0] prod100;
  logic        a0;
  logic [13:0] yp;
  logic [3:0]  mm0;
  logic [14:0] yy;
  logic [22:0] yy365, p;

  logic [13:0] a19w, cw;
  logic [4:0]  a19;
  logic [6:0]  cent, yic;
  logic        leap;
  logic [6:0]  hs, t;
  logic [4:0]  h;
  logic [6:0]  bp;
  logic [22:0] jdn0;
  gdnc_item_t  mid_item;

  logic [2:0]  l;
  logic [8:0]  msum;
  logic        mflag;
  logic [7:0]  s, ed_w;
  logic        april;

  // Stage 1: split the year by 19 and 100; bulk of the date day number
  always_comb begin
    prod19  = {14'd0, item_in.year} * {14'd0, RECIP_19};
    prod100 = {13'd0, item_in.year} * {14'd0, RECIP_100};
    a0      = item_in.month < 4'd3;
    yp      = item_in.year - {13'd0, a0};
    mm0     = a0 ? item_in.month + 4'd9 : item_in.month - 4'd3;
    yy      = {1'b0, yp} + YEAR_BIAS;
    yy365   = {8'd0, yy} * 23'd365;
    p       = yy365 + {11'd0, yp[13:2]} + {18'd0, item_in.day} + {14'd0, DAYS_BEFORE[mm0]};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e1_item <= item_in;
      e1_q19  <= prod19[27:18];
      e1_q100 <= prod100[26:19];
      e1_a0   <= a0;
      e1_p    <= p;
    end
  end

  // Stage 2: remainders, leap year, epact, century terms of the day number
  always_comb begin
    a19w = e1_item.year - {4'd0, e1_q19} * 14'd19;
    a19  = a19w[4:0];
    cw   = e1_item.year - {6'd0, e1_q100} * 14'd100;
    cent = CENT_TAB[e1_q100[6:0]];
    yic  = YIC_TAB[cw[6:0]];
    leap = (cw[6:0] == 7'd0) ? (e1_q100[1:0] == 2'b00) : (e1_item.year[1:0] == 2'b00);

    // epact mod 30 from a sum below 90
    hs = {2'b00, H19_TAB[a19]} + cent;
    if (hs >= 7'd60) begin
      h = 5'(hs - 7'd60);
    end else if (hs >= 7'd30) begin
      h = 5'(hs - 7'd30);
    end else begin
      h = hs[4:0];
    end
    t = 7'd29 + {4'd0, e1_q100[1:0], 1'b0} + yic - {2'd0, h};

    // January and February count with the previous year's century
    bp   = (e1_a0 && cw[6:0] == 7'd0) ? e1_q100[6:0] - 7'd1 : e1_q100[6:0];
    jdn0 = e1_p - {16'd0, bp} + {18'd0, bp[6:2]} - JDN_DATE_BIAS;

    mid_item = e1_item;
    if (e1_item.kind == KIND_DATE) begin
      mid_item.jdn = jdn0;
      if (e1_item.feb29 && !leap) mid_item.ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e2_item <= mid_item;
      e2_a19  <= a19;
      e2_h    <= h;
      e2_t    <= t;
      e2_leap <= leap;
    end
  end

  // Stage 3: Sunday offset and the Easter date
  always_comb begin
    l     = MOD7_TAB[e2_t];
    msum  = {4'd0, e2_a19} + {4'd0, e2_h} * 9'd11 + {6'd0, l} * 9'd22;
    mflag = msum >= 9'd451;
    s     = 8'd114 + {3'd0, e2_h} + {5'd0, l} - (mflag ? 8'd7 : 8'd0);
    april = s >= 8'd124;
    ed_w  = s - (april ? 8'd123 : 8'd92);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_out.ok           <= e2_item.ok;
      res_out.jdn          <= e2_item.jdn;
      res_out.day          <= e2_item.day;
      res_out.month        <= e2_item.month;
      res_out.year         <= e2_item.year;
      res_out.leap         <= e2_leap;
      res_out.easter_month <= april ? EASTER_APRIL : EASTER_MARCH;
      res_out.easter_day   <= ed_w[4:0];
    end
  end

endmodule

>>> hdl/gregorian_day_number_convert_unit.sv
// Throughput: one word per cycle; every stage holds together only while a result waits.
// Ten register stages: the input register, five splitting the day number (two
// reciprocal-multiply-and-correct steps, then the month), three year and Easter stages,
// and the output register. Reset (rst, synchronous, active high) clears the stage valid
// flags and holds s_tready low; data is not reset.
`include "assert_macros.svh"

module gregorian_day_number_convert_unit import gdnc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // in_year[13:0], in_month[17:14], in_day[22:18],
                                // in_day_number[45:23], zero[47:46]
  input  logic        s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // day_number[22:0], out_day[27:23], out_month[31:28],
                                // out_year[45:32], weekday_index[48:46], leap_year[49],
                                // easter_month[52:50], easter_day[57:53], zero[63:58]
  output logic        m_tuser   // valid_res
);

  localparam int PIPE_DEPTH = 1 + J2D_LAT + CAL_LAT;

  logic                  advance;
  logic [PIPE_DEPTH-1:0] pipe_vld;
  gdnc_item_t            in_item, s0_item, split_item;
  gdnc_result_t          cal_res, out_res;
  logic                  out_vld;
  logic [2:0]            out_wday;
  logic                  date_ok, num_ok;

  logic [5:0]  wk_sum;
  logic [3:0]  wk_fold;
  logic [3:0]  wk_mod;
  logic [23:0] wk_src;
  logic [2:0]  wday;

  // Whole pipeline moves unless the output word is held
  assign advance  = !out_vld || m_tready;
  assign s_tready = advance && !rst;
  assign m_tvalid = out_vld;

  // Unpack and range-check the incoming word
  always_comb begin
    in_item.kind  = s_tuser;
    in_item.year  = s_tdata[13:0];
    in_item.month = s_tdata[17:14];
    in_item.day   = s_tdata[22:18];
    in_item.jdn   = s_tdata[45:23];
    date_ok = (in_item.year != 14'd0) && (in_item.year <= YEAR_MAX) &&
              (in_item.day != 5'd0) && (in_item.day <= max_days(in_item.month));
    num_ok  = (in_item.jdn >= JDN_MIN) && (in_item.jdn <= JDN_MAX);
    in_item.ok    = (in_item.kind == KIND_NUMBER) ? num_ok : date_ok;
    in_item.feb29 = (in_item.month == 4'd2) && (in_item.day == 5'd29);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_item <= in_item;
    end
  end

  // Valid flags follow the data stages
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= '0;
      out_vld  <= 1'b0;
    end else if (advance) begin
      pipe_vld <= {pipe_vld[PIPE_DEPTH-2:0], s_tvalid};
      out_vld  <= pipe_vld[PIPE_DEPTH-1];
    end
  end

  gdnc_jdn_split u_split (
    .clk      (clk),
    .advance  (advance),
    .item_in  (s0_item),
    .item_out (split_item)
  );

  gdnc_calendar u_cal (
    .clk     (clk),
    .advance (advance),
    .item_in (split_item),
    .res_out (cal_res)
  );

  // Weekday: 8 == 1 mod 7, so fold 3-bit digits
  always_comb begin
    wk_src = {1'b0, cal_res.jdn};
    wk_sum = '0;
    for (int k = 0; k < 8; k++) begin
      wk_sum = wk_sum + {3'd0, wk_src[3*k +: 3]};
    end
    wk_fold = {1'b0, wk_sum[5:3]} + {1'b0, wk_sum[2:0]};
    wk_mod  = {1'b0, wk_fold[2:0]} + {3'd0, wk_fold[3]};
    wday    = (wk_mod >= 4'd7) ? 3'(wk_mod - 4'd7) : wk_mod[2:0];
  end

  // Output register, zeroed for a rejected word
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cal_res.ok) begin
        out_res  <= cal_res;
        out_wday <= wday;
      end else begin
        out_res  <= '0;
        out_wday <= 3'd0;
      end
    end
  end

  assign m_tuser = out_res.ok;
  assign m_tdata = {6'd0, out_res.easter_day, out_res.easter_month, out_res.leap, out_wday,
                    out_res.year, out_res.month, out_res.day, out_res.jdn};

  `ASSERT_IMPLIES(a_reject_zero, m_tvalid && !m_tuser, m_tdata == 64'd0, "rejected word not zero")
  `ASSERT_IMPLIES(a_date_range, m_tvalid && m_tuser, out_res.month >= 4'd1 && out_res.month <= 4'd12 && out_res.day != 5'd0, "date out of range")
  `ASSERT_IMPLIES(a_easter_wday, m_tvalid && m_tuser, (out_res.easter_month == EASTER_MARCH || out_res.easter_month == EASTER_APRIL) && out_wday <= 3'd6, "easter month or weekday bad")
  `ASSERT_IMPLIES(a_leap_div4, m_tvalid && m_tuser && out_res.leap, out_res.year[1:0] == 2'b00, "leap year not divisible by 4")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gdnc_pkg::*;

  // One request word: a date or a day number, selected by kind
  typedef struct packed {
    logic        kind;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [22:0] jdn;
  } date_req_t;

  // One result word, ordered as unpacked from m_tuser / m_tdata
  typedef struct packed {
    logic        valid;
    logic [22:0] jdn;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  wday;
    logic        leap;
    logic [2:0]  emon;
    logic [4:0]  eday;
  } date_res_t;

  localparam int N_RANDOM   = 2000;
  localparam int CALM_TAIL  = 300;   // last words run with no idling
  localparam int HOLD_AFTER = 300;   // receiver hold-off starts after this many words
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_AT   = 1200;  // sender waits for an empty pipe after this many words
  localparam int LATENCY    = 10;
  localparam int MAX_SHOWN  = 10;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        s_tuser  = KIND_DATE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  date_req_t req_q[$];     // words waiting to be sent
  date_res_t date_q[$];    // converted dates still owed by the block
  date_req_t on_bus;
  date_req_t nxt_req;
  date_res_t got;
  date_res_t want;
  int        n_total  = 0;
  int        issued   = 0;
  int        acc_cnt  = 0;
  int        rcv_cnt  = 0;
  int        err_cnt  = 0;
  int        tx_gap   = 0;
  int        rx_stall = 0;
  logic      hold_rx  = 1'b0;

  gregorian_day_number_convert_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // in_year, in_month, in_day, in_day_number, zero pad
    .s_tuser  (s_tuser),   // kind
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // day_number, day, month, year, weekday, leap, easter m/d
    .m_tuser  (m_tuser)    // valid_res
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Calendar arithmetic
  function automatic bit is_leap_year(int y);
    return (y % 400 == 0) || (y % 100 != 0 && y % 4 == 0);
  endfunction

  function automatic int month_days(int m, int y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic int fmod(int x, int n);
    return ((x % n) + n) % n;
  endfunction

  // Expected result word for one request
  function automatic date_res_t convert_date(date_req_t r);
    date_res_t res;
    int y, m, d, j;
    int shift, ey, em;
    int q400, rem400, q4, rem4, mi;
    int gold, cent, yic, epact, dow_term, corr, sday;
    bit ok;
    res = '0;
    y = r.year;
    m = r.month;
    d = r.day;
    j = r.jdn;
    if (r.kind == KIND_DATE) begin
      ok = y >= 1 && y <= 9999 && m >= 1 && m <= 12 && d >= 1 && d <= month_days(m, y);
      if (ok) begin
        // count years from March so February sits at the end
        shift = (14 - m) / 12;
        ey    = y + 4800 - shift;
        em    = m + 12 * shift - 3;
        j     = d + (153 * em + 2) / 5 + 365 * ey + ey / 4 - ey / 100 + ey / 400 - 32045;
      end
    end else begin
      ok = j >= int'(JDN_MIN) && j <= int'(JDN_MAX);
      if (ok) begin
        // split into 400-year and 4-year cycles, then month from March
        q400   = (4 * (j + 32044) + 3) / 146097;
        rem400 = j + 32044 - 146097 * q400 / 4;
        q4     = (4 * rem400 + 3) / 1461;
        rem4   = rem400 - 1461 * q4 / 4;
        mi     = (5 * rem4 + 2) / 153;
        d      = rem4 - (153 * mi + 2) / 5 + 1;
        m      = mi + 3 - 12 * (mi / 10);
        y      = 100 * q400 + q4 - 4800 + mi / 10;
      end
    end
    if (!ok) return res;

    // Gregorian Easter of the year
    gold     = y % 19;
    cent     = y / 100;
    yic      = y % 100;
    epact    = fmod(19 * gold + cent - cent / 4 - (cent - (cent + 8) / 25 + 1) / 3 + 15, 30);
    dow_term = fmod(32 + 2 * (cent % 4) + 2 * (yic / 4) - epact - yic % 4, 7);
    corr     = (gold + 11 * epact + 22 * dow_term) / 451;
    sday     = epact + dow_term - 7 * corr + 114;

    res.valid = 1'b1;
    res.jdn   = 23'(j);
    res.day   = 5'(d);
    res.month = 4'(m);
    res.year  = 14'(y);
    res.wday  = 3'(j % 7);
    res.leap  = is_leap_year(y);
    res.emon  = 3'(sday / 31);
    res.eday  = 5'(sday % 31 + 1);
    return res;
  endfunction

  function automatic date_req_t mk_req(logic k, int y, int m, int d, int j);
    date_req_t r;
    r.kind  = k;
    r.year  = 14'(y);
    r.month = 4'(m);
    r.day   = 5'(d);
    r.jdn   = 23'(j);
    return r;
  endfunction

  // Mostly well-formed dates and day numbers; unused fields always random
  function automatic date_req_t random_req();
    date_req_t r;
    int pick;
    int y, m;
    r = mk_req(KIND_DATE, $urandom_range(0, 9999), $urandom_range(0, 15),
               $urandom_range(0, 31), $urandom_range(0, JDN_MAX));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      y = $urandom_range(1, 9999);
      m = $urandom_range(1, 12);
      r.year  = 14'(y);
      r.month = 4'(m);
      r.day   = 5'($urandom_range(1, month_days(m, y)));
    end else if (pick < 50) begin
      // end of February, leap or not
      r.year  = 14'($urandom_range(1, 9999));
      r.month = 4'd2;
      r.day   = 5'($urandom_range(28, 29));
    end else if (pick < 60) begin
      // raw date fields, often invalid
    end else if (pick < 90) begin
      r.kind = KIND_NUMBER;
      r.jdn  = 23'($urandom_range(JDN_MIN, JDN_MAX));
    end else begin
      r.kind = KIND_NUMBER;
    end
    return r;
  endfunction

  function automatic bit may_idle(int n);
    return n < n_total - CALM_TAIL && (n / 150) % 4 != 3;
  endfunction

  function automatic string show(date_res_t r);
    return $sformatf("ok=%0d jdn=%0d d=%0d m=%0d y=%0d wd=%0d leap=%0d easter=%0d/%0d",
                     r.valid, r.jdn, r.day, r.month, r.year, r.wday, r.leap,
                     r.emon, r.eday);
  endfunction

  // Driver: one word on the bus at a time, random gaps after some words
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        date_q.push_back(convert_date(on_bus));
        acc_cnt <= acc_cnt + 1;
      end
      if (s_tvalid && !s_tready) begin
        // word not taken yet, keep it
      end else if (tx_gap != 0) begin
        tx_gap   <= tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (req_q.size() == 0 ||
                   (issued == DRAIN_AT && (acc_cnt != issued || rcv_cnt != issued))) begin
        s_tvalid <= 1'b0;
      end else begin
        nxt_req = req_q.pop_front();
        on_bus   <= nxt_req;
        s_tdata  <= {2'b00, nxt_req.jdn, nxt_req.day, nxt_req.month, nxt_req.year};
        s_tuser  <= nxt_req.kind;
        s_tvalid <= 1'b1;
        issued = issued + 1;
        if (may_idle(issued) && $urandom_range(0, 7) == 0) begin
          tx_gap <= $urandom_range(1, 17);
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expected date
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[22:0], m_tdata[27:23], m_tdata[31:28], m_tdata[45:32],
               m_tdata[48:46], m_tdata[49], m_tdata[52:50], m_tdata[57:53]};
        rcv_cnt <= rcv_cnt + 1;
        if (date_q.size() == 0) begin
          if (err_cnt < MAX_SHOWN) $display("unexpected result word: %s", show(got));
          err_cnt++;
        end else begin
          want = date_q.pop_front();
          if (got !== want) begin
            if (err_cnt < MAX_SHOWN) begin
              $display("word %0d mismatch\n  expected %s\n  actual   %s",
                       rcv_cnt, show(want), show(got));
            end
            err_cnt++;
          end
        end
      end
      // backpressure: long hold-off, random stall bursts, or ready
      if (hold_rx) begin
        m_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        m_tready <= 1'b0;
      end else if (may_idle(rcv_cnt) && $urandom_range(0, 9) == 0) begin
        rx_stall <= $urandom_range(0, 16);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and stalls the input
  initial begin
    wait (acc_cnt >= HOLD_AFTER);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Stimulus, reset and end of run
  initial begin
    // range ends; unused day number field set to extremes
    req_q.push_back(mk_req(KIND_DATE, 1, 1, 1, JDN_MAX));
    req_q.push_back(mk_req(KIND_DATE, 9999, 12, 31, 0));
    // leap rules: 400-year, 100-year and 4-year
    req_q.push_back(mk_req(KIND_DATE, 2000, 2, 29, 0));
    req_q.push_back(mk_req(KIND_DATE, 1900, 2, 29, 0));
    req_q.push_back(mk_req(KIND_DATE, 1900, 2, 28, 0));
    req_q.push_back(mk_req(KIND_DATE, 2024, 2, 29, 0));
    req_q.push_back(mk_req(KIND_DATE, 2023, 2, 29, 0));
    req_q.push_back(mk_req(KIND_DATE, 1600, 2, 29, 0));
    // bad year, month and day, then a valid January 31
    req_q.push_back(mk_req(KIND_DATE, 0, 1, 1, 0));
    req_q.push_back(mk_req(KIND_DATE, 2020, 0, 10, 0));
    req_q.push_back(mk_req(KIND_DATE, 2020, 13, 1, 0));
    req_q.push_back(mk_req(KIND_DATE, 2020, 15, 31, 0));
    req_q.push_back(mk_req(KIND_DATE, 2020, 5, 0, 0));
    req_q.push_back(mk_req(KIND_DATE, 2021, 4, 31, 0));
    req_q.push_back(mk_req(KIND_DATE, 2021, 1, 31, 0));
    // earliest and latest Easter
    req_q.push_back(mk_req(KIND_DATE, 1818, 3, 22, 0));
    req_q.push_back(mk_req(KIND_DATE, 2038, 4, 25, 0));
    // day number range edges; unused date fields at extremes
    req_q.push_back(mk_req(KIND_NUMBER, 0, 0, 0, 0));
    req_q.push_back(mk_req(KIND_NUMBER, 9999, 15, 31, JDN_MIN - 1));
    req_q.push_back(mk_req(KIND_NUMBER, 9999, 15, 31, JDN_MIN));
    req_q.push_back(mk_req(KIND_NUMBER, 0, 0, 0, JDN_MAX));
    req_q.push_back(mk_req(KIND_NUMBER, 0, 0, 0, 2451604));
    req_q.push_back(mk_req(KIND_NUMBER, 0, 0, 0, 2415079));
    repeat (N_RANDOM) req_q.push_back(random_req());
    n_total = req_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (acc_cnt == n_total);
    while (rcv_cnt != n_total) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    if (err_cnt == 0 && date_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
